>>> rtl/core/dmaag_pkg.sv
// Shared types, register map constants and helpers for the DMA address generator.
`default_nettype none

package dmaag_pkg;

  localparam int unsigned NUM_CH    = 4;
  localparam int unsigned HW_PER_CH = 6;
  localparam int unsigned NUM_REGS  = NUM_CH * HW_PER_CH;

  // operation codes of an input word
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  // halfword slots inside one channel row
  localparam logic [2:0] HW_SRC_LO = 3'd0;
  localparam logic [2:0] HW_SRC_HI = 3'd1;
  localparam logic [2:0] HW_DST_LO = 3'd2;
  localparam logic [2:0] HW_DST_HI = 3'd3;
  localparam logic [2:0] HW_COUNT  = 3'd4;
  localparam logic [2:0] HW_CTRL   = 3'd5;

  // control writes that latch the source of channels 1 and 2
  localparam logic [4:0] LATCH_IDX_CH1 = 5'd11;
  localparam logic [4:0] LATCH_IDX_CH2 = 5'd17;

  localparam logic [15:0] START_MASK     = 16'hB000;
  localparam logic [15:0] START_PATTERN  = 16'h8000;
  localparam logic [15:0] ENABLE_CLEAR   = 16'h7FFF;
  localparam logic [31:0] SRC_MODE_LIMIT = 32'h0800_0000;
  localparam logic [17:0] LEN_ZERO       = 18'h0_4000;
  localparam logic [17:0] LEN_ZERO_CH3   = 18'h1_0000;
  localparam logic [1:0]  LAST_CH        = 2'd3;

  typedef enum logic [1:0] {
    STEP_INC   = 2'd0,
    STEP_DEC   = 2'd1,
    STEP_FIXED = 2'd2
  } step_t;

  typedef logic [HW_PER_CH-1:0][15:0] row_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [4:0]  reg_index;
    logic [15:0] write_data;
  } in_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        unit_valid;
    logic [1:0]  unit_channel;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic        last_unit;
    logic        irq_raise;
    logic        busy_res;
  } out_t;

  // one row write with halfword enables
  typedef struct packed {
    logic [1:0]           row;
    logic [HW_PER_CH-1:0] hw_en;
    row_t                 data;
  } rf_wr_t;

  function automatic logic [1:0] reg_row(input logic [4:0] idx);
    logic [1:0] r;
    if (idx < 5'(HW_PER_CH)) r = 2'd0;
    else if (idx < 5'(2 * HW_PER_CH)) r = 2'd1;
    else if (idx < 5'(3 * HW_PER_CH)) r = 2'd2;
    else r = 2'd3;
    return r;
  endfunction

  function automatic logic [2:0] reg_sub(input logic [4:0] idx);
    logic [4:0] d;
    if (idx < 5'(HW_PER_CH)) d = idx;
    else if (idx < 5'(2 * HW_PER_CH)) d = idx - 5'(HW_PER_CH);
    else if (idx < 5'(3 * HW_PER_CH)) d = idx - 5'(2 * HW_PER_CH);
    else if (idx < 5'(NUM_REGS)) d = idx - 5'(3 * HW_PER_CH);
    else d = '0;
    return d[2:0];
  endfunction

  function automatic step_t mode_to_step(input logic [1:0] mode);
    step_t s;
    case (mode)
      2'd1:    s = STEP_DEC;
      2'd2:    s = STEP_FIXED;
      default: s = STEP_INC;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] advance(input logic [31:0] a, input step_t s);
    logic [31:0] r;
    case (s)
      STEP_DEC:   r = a - 32'd2;
      STEP_FIXED: r = a;
      default:    r = a + 32'd2;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/dmaag_reg_ram.sv
// Channel register memory: one row per channel, halfword write enables, forwarding.
`default_nettype none

module dmaag_reg_ram (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            rd_en,
  input  wire logic [1:0]      rd_row,
  output dmaag_pkg::row_t      rd_data,
  input  wire dmaag_pkg::rf_wr_t wr
);
  import dmaag_pkg::*;

  row_t                 mem [NUM_CH];
  logic [HW_PER_CH-1:0] vld_r [NUM_CH];
  row_t                 rdata_r;
  logic [HW_PER_CH-1:0] rvld_r;
  row_t                 fwd_data_r;
  logic [HW_PER_CH-1:0] fwd_en_r;

  always_ff @(posedge clk) begin
    for (int h = 0; h < HW_PER_CH; h++) begin
      if (wr.hw_en[h]) begin
        mem[wr.row][h] <= wr.data[h];
      end
    end
    if (rd_en) begin
      rdata_r    <= mem[rd_row];
      fwd_data_r <= wr.data;
    end
  end

  // valid bits stand in for clearing the rows at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_CH; r++) begin
        vld_r[r] <= '0;
      end
      rvld_r   <= '0;
      fwd_en_r <= '0;
    end else begin
      vld_r[wr.row] <= vld_r[wr.row] | wr.hw_en;
      if (rd_en) begin
        rvld_r   <= vld_r[rd_row];
        // same-cycle write to the row being read: forward it
        fwd_en_r <= (wr.row == rd_row) ? wr.hw_en : '0;
      end
    end
  end

  always_comb begin
    for (int h = 0; h < HW_PER_CH; h++) begin
      if (fwd_en_r[h]) rd_data[h] = fwd_data_r[h];
      else if (rvld_r[h]) rd_data[h] = rdata_r[h];
      else rd_data[h] = '0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/four_channel_dma_address_generator_unit.sv
// Four-channel DMA address generator: register block and per-unit address stepping.
//
// Input channel in_valid/in_ready/in_data carries one word: a register write,
// a register read or a step request. Every accepted word yields exactly one
// result word on out_valid/out_ready/out_data.
// A word is accepted and its channel row is read from the register memory at
// that edge; in the row-access stage the row is modified and written back
// and the result lands in the output register that drives out_valid.
// Throughput is one word per cycle unless the receiver stalls; a write
// followed at once by an access to the same row is served from the
// forwarding path of the register memory.
// A step word emits one halfword source/destination address pair of the
// running transfer; the final unit performs the repeat write-back or enable
// clear in that same row access.
// After reset all registers read as zero and no transfer runs.
// When the receiver stalls, the result holds in the output register, one more
// word may wait in the row-access stage, and in_ready then drops.
`default_nettype none

module four_channel_dma_address_generator_unit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output      logic           in_ready,
  input  wire dmaag_pkg::in_t in_data,
  output      logic           out_valid,
  input  wire logic           out_ready,
  output dmaag_pkg::out_t     out_data
);
  import dmaag_pkg::*;

  // pipeline control
  logic        in_accept;
  logic        s1_fire;
  logic        s1_valid_r;
  in_t         s1_item_r;
  logic        out_valid_r;
  out_t        out_data_r;

  // transfer state
  logic        active_r,   active_nxt;
  logic [1:0]  act_ch_r,   act_ch_nxt;
  logic [31:0] cur_src_r,  cur_src_nxt;
  logic [31:0] cur_dst_r,  cur_dst_nxt;
  logic [17:0] units_r,    units_nxt;
  step_t       src_step_r, src_step_nxt;
  step_t       dst_step_r, dst_step_nxt;
  logic [15:0] act_ctrl_r, act_ctrl_nxt;
  logic [31:0] latched_r [2];
  logic [31:0] latched_nxt [2];

  // memory ports
  logic        rd_en;
  logic [1:0]  rd_row;
  row_t        row;
  rf_wr_t      wr_req;
  rf_wr_t      wr_gated;

  // stage 1 decode
  logic [4:0]  idx;
  logic [15:0] wdat;
  logic        in_rng;
  logic [1:0]  rrow;
  logic [2:0]  rsub;
  logic        is_write;
  logic        start_hit;
  logic        wide;
  logic [17:0] len;
  logic [31:0] src_al;
  logic [31:0] dst_al;
  out_t        res;

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_fire;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // step words read the row of the channel that will be active
  assign rd_en  = in_accept;
  assign rd_row = (in_data.operation == OP_STEP) ? (s1_fire ? act_ch_nxt : act_ch_r)
                                                 : reg_row(in_data.reg_index);

  always_comb begin
    wr_gated       = wr_req;
    wr_gated.hw_en = s1_fire ? wr_req.hw_en : '0;
  end

  dmaag_reg_ram u_reg_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_row  (rd_row),
    .rd_data (row),
    .wr      (wr_gated)
  );

  always_comb begin
    idx       = s1_item_r.reg_index;
    wdat      = s1_item_r.write_data;
    in_rng    = idx < 5'(NUM_REGS);
    rrow      = reg_row(idx);
    rsub      = reg_sub(idx);
    is_write  = (s1_item_r.operation == OP_WRITE) && in_rng;
    start_hit = is_write && (rsub == HW_CTRL) && ((wdat & START_MASK) == START_PATTERN);
    wide      = wdat[10];

    len = (row[HW_COUNT] == 16'd0) ? ((rrow == LAST_CH) ? LEN_ZERO_CH3 : LEN_ZERO)
                                   : {2'b00, row[HW_COUNT]};
    if (wide) len = {len[16:0], 1'b0};
    src_al = {row[HW_SRC_HI], row[HW_SRC_LO][15:2], row[HW_SRC_LO][1] & ~wide, 1'b0};
    dst_al = {row[HW_DST_HI], row[HW_DST_LO][15:2], row[HW_DST_LO][1] & ~wide, 1'b0};

    active_nxt     = active_r;
    act_ch_nxt     = act_ch_r;
    cur_src_nxt    = cur_src_r;
    cur_dst_nxt    = cur_dst_r;
    units_nxt      = units_r;
    src_step_nxt   = src_step_r;
    dst_step_nxt   = dst_step_r;
    act_ctrl_nxt   = act_ctrl_r;
    latched_nxt[0] = latched_r[0];
    latched_nxt[1] = latched_r[1];

    wr_req.row   = rrow;
    wr_req.hw_en = '0;
    wr_req.data  = row;

    res = '0;

    case (s1_item_r.operation)
      OP_WRITE: begin
        if (in_rng) begin
          wr_req.hw_en[rsub] = 1'b1;
          wr_req.data[rsub]  = start_hit ? (wdat & ENABLE_CLEAR) : wdat;
          if (idx == LATCH_IDX_CH1 && wdat[15]) begin
            latched_nxt[0] = {row[HW_SRC_HI], row[HW_SRC_LO]};
          end
          if (idx == LATCH_IDX_CH2 && wdat[15]) begin
            latched_nxt[1] = {row[HW_SRC_HI], row[HW_SRC_LO]};
          end
          // a start write while no transfer runs loads the transfer state from this row
          if (start_hit && !active_r) begin
            src_step_nxt = (src_al < SRC_MODE_LIMIT) ? mode_to_step(wdat[8:7]) : STEP_INC;
            dst_step_nxt = mode_to_step(wdat[6:5]);
            cur_src_nxt  = src_al;
            cur_dst_nxt  = dst_al;
            units_nxt    = len;
            act_ctrl_nxt = wdat;
            act_ch_nxt   = rrow;
            active_nxt   = 1'b1;
          end
        end
      end
      OP_READ: begin
        if (in_rng) res.read_data = row[rsub];
      end
      OP_STEP: begin
        if (active_r) begin
          res.unit_valid     = 1'b1;
          res.unit_channel   = act_ch_r;
          res.source_address = cur_src_r;
          res.dest_address   = cur_dst_r;
          cur_src_nxt = advance(cur_src_r, src_step_r);
          cur_dst_nxt = advance(cur_dst_r, dst_step_r);
          units_nxt   = units_r - 18'd1;
          if (units_nxt == 18'd0) begin
            res.last_unit = 1'b1;
            res.irq_raise = act_ctrl_r[14];
            active_nxt    = 1'b0;
            wr_req.row    = act_ch_r;
            if (!act_ctrl_r[9]) begin
              // drop the enable bit
              wr_req.hw_en[HW_CTRL] = 1'b1;
              wr_req.data[HW_CTRL]  = row[HW_CTRL] & ENABLE_CLEAR;
            end else begin
              if (act_ctrl_r[6:5] < 2'd2) begin
                wr_req.hw_en[HW_DST_LO] = 1'b1;
                wr_req.hw_en[HW_DST_HI] = 1'b1;
                wr_req.data[HW_DST_LO]  = cur_dst_nxt[15:0];
                wr_req.data[HW_DST_HI]  = cur_dst_nxt[31:16];
              end
              if (act_ch_r == 2'd1) begin
                latched_nxt[0] = cur_src_nxt;
              end else if (act_ch_r == 2'd2) begin
                latched_nxt[1] = cur_src_nxt;
              end else begin
                wr_req.hw_en[HW_SRC_LO] = 1'b1;
                wr_req.hw_en[HW_SRC_HI] = 1'b1;
                wr_req.data[HW_SRC_LO]  = cur_src_nxt[15:0];
                wr_req.data[HW_SRC_HI]  = cur_src_nxt[31:16];
              end
            end
          end
        end
      end
      default: begin
      end
    endcase

    res.busy_res = active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      active_r     <= 1'b0;
      act_ch_r     <= '0;
      cur_src_r    <= '0;
      cur_dst_r    <= '0;
      units_r      <= '0;
      src_step_r   <= STEP_INC;
      dst_step_r   <= STEP_INC;
      act_ctrl_r   <= '0;
      latched_r[0] <= '0;
      latched_r[1] <= '0;
    end else begin
      if (in_accept) s1_valid_r <= 1'b1;
      else if (s1_fire) s1_valid_r <= 1'b0;

      if (s1_fire) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      if (s1_fire) begin
        active_r     <= active_nxt;
        act_ch_r     <= act_ch_nxt;
        cur_src_r    <= cur_src_nxt;
        cur_dst_r    <= cur_dst_nxt;
        units_r      <= units_nxt;
        src_step_r   <= src_step_nxt;
        dst_step_r   <= dst_step_nxt;
        act_ctrl_r   <= act_ctrl_nxt;
        latched_r[0] <= latched_nxt[0];
        latched_r[1] <= latched_nxt[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) s1_item_r <= in_data;
    if (s1_fire) out_data_r <= res;
  end

endmodule

`default_nettype wire
